### src/tkf_pkg.sv
// Package: shared types, constants and helper functions of the tilt Kalman filter.
package tkf_pkg;

	localparam int unsigned DataW = 32;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned Frac = 24;
	localparam int unsigned QuoW = 57;

	localparam logic [CfgIdxW-1:0] CfgSamplePeriod = 3'd0;
	localparam logic [CfgIdxW-1:0] CfgAngleNoise = 3'd1;
	localparam logic [CfgIdxW-1:0] CfgBiasNoise = 3'd2;
	localparam logic [CfgIdxW-1:0] CfgMeasNoise = 3'd3;
	localparam logic [CfgIdxW-1:0] CfgObserveGain = 3'd4;

	localparam logic signed [DataW-1:0] OneQ24 = 32'sd16777216;
	localparam logic signed [DataW-1:0] RstSamplePeriod = 32'sd83886;
	localparam logic signed [DataW-1:0] RstAngleNoise = 32'sd16777;
	localparam logic signed [DataW-1:0] RstBiasNoise = 32'sd50332;
	localparam logic signed [DataW-1:0] RstMeasNoise = 32'sd8388608;

	// Sequencer states. Each multiply state issues one 33x33 product.
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RATE,
		ST_ANG,
		ST_ERR,
		ST_PDOT,
		ST_P00,
		ST_P01,
		ST_P10,
		ST_P11,
		ST_PC0,
		ST_PC1,
		ST_T1,
		ST_E,
		ST_DIV0,
		ST_DIV1,
		ST_UP00,
		ST_UP01,
		ST_UP10,
		ST_UP11,
		ST_UANG,
		ST_UBIAS,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic signed [QuoW-1:0] dividend;
		logic signed [DataW-1:0] divisor;
	} div_req_t;

	function automatic logic signed [DataW-1:0] sat32(input logic signed [65:0] x);
		if (x > 66'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (x < -66'sd2147483648) begin
			return 32'sh80000000;
		end
		return x[DataW-1:0];
	endfunction

endpackage

### src/tkf_if.sv
// Interfaces: valid/ready channels for samples and estimates.
interface tkf_in_if;
	logic valid;
	logic ready;
	logic [31:0] angle_meas;
	logic [31:0] gyro_rate;
	modport source(output valid, angle_meas, gyro_rate, input ready);
	modport sink(input valid, angle_meas, gyro_rate, output ready);
endinterface

interface tkf_out_if;
	logic valid;
	logic ready;
	logic [31:0] angle_est;
	logic [31:0] rate_est;
	logic [31:0] bias_est;
	logic div_fault;
	modport source(output valid, angle_est, rate_est, bias_est, div_fault, input ready);
	modport sink(input valid, angle_est, rate_est, bias_est, div_fault, output ready);
endinterface

### src/tkf_div.sv
// Restoring divider, one quotient bit per cycle, signed with truncation toward zero.
module tkf_div
	import tkf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input div_req_t req,
	output logic busy,
	output logic signed [QuoW-1:0] quotient
);

	localparam int unsigned CntW = $clog2(QuoW + 1);

	logic [QuoW-1:0] num_q;
	logic [DataW-1:0] den_q;
	logic [DataW-1:0] rem_q;
	logic [CntW-1:0] cnt_q;
	logic neg_q;
	logic [DataW:0] trial;
	logic [QuoW-1:0] mag_n;
	logic [DataW-1:0] mag_d;

	assign mag_n = req.dividend[QuoW-1] ? QuoW'(-req.dividend) : QuoW'(req.dividend);
	assign mag_d = req.divisor[DataW-1] ? DataW'(-req.divisor) : DataW'(req.divisor);
	assign trial = {rem_q, num_q[QuoW-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= CntW'(QuoW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// The partial remainder stays below the divisor, so it always fits in DataW bits.
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= mag_n;
			den_q <= mag_d;
			rem_q <= '0;
			neg_q <= req.dividend[QuoW-1] ^ req.divisor[DataW-1];
		end else if (cnt_q != '0) begin
			if (!trial[DataW]) begin
				rem_q <= trial[DataW-1:0];
				num_q <= {num_q[QuoW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DataW-2:0], num_q[QuoW-1]};
				num_q <= {num_q[QuoW-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quotient = neg_q ? -$signed(num_q) : $signed(num_q);

endmodule

### src/tkf_mul.sv
// Shared multiplier: registered 33x33 signed product, floor-shifted by 24.
module tkf_mul
	import tkf_pkg::*;
(
	input logic clk,
	input logic signed [DataW:0] a,
	input logic signed [DataW:0] b,
	output logic signed [65:0] prod_q
);

	logic signed [65:0] full;

	assign full = a * b;

	// Arithmetic shift gives floor rounding.
	always_ff @(posedge clk) begin
		prod_q <= full >>> Frac;
	end

endmodule

### src/tilt_kalman_filter.sv
// Top level: sequencer, state registers and configuration of the tilt Kalman filter.
// A result takes two divisions and 15 multiply steps through one shared multiplier; the
// divider is not started when the innovation variance is zero. A new request is accepted
// only in idle, after the previous result has been moved to the output register.
// The result waits in an output register; a new result stalls only while the old one is held.
// Reset (arst_n low) returns registers to defaults, zeroes angle and bias and sets the
// covariance to identity.
module tilt_kalman_filter
	import tkf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	tkf_in_if.sink in_ch,
	tkf_out_if.source out_ch,
	input logic cfg_we,
	input logic [CfgIdxW-1:0] cfg_index,
	input logic [DataW-1:0] cfg_data
);

	state_t state_q, state_n;
	logic signed [DataW-1:0] dt_q, qa_q, qg_q, r_q, c0_q;
	logic signed [DataW-1:0] angle_q, bias_q, p00_q, p01_q, p10_q, p11_q;
	logic signed [DataW-1:0] meas_q, gyro_q, rate_q, ang_q, err_q, pdot_q;
	logic signed [DataW-1:0] pc0_q, pc1_q, t1_q, e_q, k0_q, k1_q;
	logic fault_q, wait_q;
	logic signed [DataW:0] ma, mb;
	logic signed [65:0] prod;
	div_req_t dreq;
	logic dbusy;
	logic signed [QuoW-1:0] quo;
	logic [DataW-1:0] res_ang_q, res_rate_q, res_bias_q;
	logic res_fault_q, out_valid_q;
	logic out_free;

	tkf_mul u_mul (.clk(clk), .a(ma), .b(mb), .prod_q(prod));
	tkf_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .busy(dbusy), .quotient(quo));

	assign out_free = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= RstSamplePeriod;
			qa_q <= RstAngleNoise;
			qg_q <= RstBiasNoise;
			r_q <= RstMeasNoise;
			c0_q <= OneQ24;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgSamplePeriod: dt_q <= {1'b0, cfg_data[30:0]};
				CfgAngleNoise: qa_q <= {1'b0, cfg_data[30:0]};
				CfgBiasNoise: qg_q <= {1'b0, cfg_data[30:0]};
				CfgMeasNoise: r_q <= {1'b0, cfg_data[30:0]};
				CfgObserveGain: c0_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Multiplier operand selection per state; the product is registered and appears in the next cycle.
	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			ST_ANG: begin ma = 33'(rate_q); mb = 33'(dt_q); end
			ST_P00: begin ma = 33'(pdot_q); mb = 33'(dt_q); end
			ST_P01, ST_P10: begin ma = -33'(p11_q); mb = 33'(dt_q); end
			ST_P11: begin ma = 33'(qg_q); mb = 33'(dt_q); end
			ST_PC0: begin ma = 33'(c0_q); mb = 33'(p00_q); end
			ST_PC1: begin ma = 33'(c0_q); mb = 33'(p10_q); end
			ST_T1: begin ma = 33'(c0_q); mb = 33'(p01_q); end
			ST_E: begin ma = 33'(c0_q); mb = 33'(pc0_q); end
			ST_UP00: begin ma = 33'(k0_q); mb = 33'(pc0_q); end
			ST_UP01: begin ma = 33'(k0_q); mb = 33'(t1_q); end
			ST_UP10: begin ma = 33'(k1_q); mb = 33'(pc0_q); end
			ST_UP11: begin ma = 33'(k1_q); mb = 33'(t1_q); end
			ST_UANG: begin ma = 33'(k0_q); mb = 33'(err_q); end
			ST_UBIAS: begin ma = 33'(k1_q); mb = 33'(err_q); end
			default: ;
		endcase
	end

	always_comb begin
		dreq.start = 1'b0;
		dreq.dividend = '0;
		dreq.divisor = e_q;
		if (!wait_q && (e_q != '0)) begin
			if (state_q == ST_DIV0) begin
				dreq.start = 1'b1;
				dreq.dividend = QuoW'(pc0_q) <<< Frac;
			end else if (state_q == ST_DIV1) begin
				dreq.start = 1'b1;
				dreq.dividend = QuoW'(pc1_q) <<< Frac;
			end
		end
	end

	// Each multiply state holds until wait_q is set, so the registered product is ready when used.
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: if (in_ch.valid) state_n = ST_RATE;
			ST_RATE: state_n = ST_ANG;
			ST_ERR: state_n = ST_PDOT;
			ST_PDOT: state_n = ST_P00;
			ST_DIV0, ST_DIV1: begin
				if (e_q == '0 || (wait_q && !dbusy)) begin
					state_n = (state_q == ST_DIV0) ? ST_DIV1 : ST_UP00;
				end
			end
			ST_OUT: if (out_free) state_n = ST_IDLE;
			default: if (wait_q) state_n = state_t'(state_q + 1'b1);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wait_q <= 1'b0;
			out_valid_q <= 1'b0;
			angle_q <= '0;
			bias_q <= '0;
			p00_q <= OneQ24;
			p01_q <= '0;
			p10_q <= '0;
			p11_q <= OneQ24;
		end else begin
			state_q <= state_n;
			wait_q <= (state_n == state_q) && !wait_q ? 1'b1 : ((state_n == state_q) ? wait_q : 1'b0);
			if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
			if (wait_q) begin
				case (state_q)
					ST_P00: p00_q <= sat32(66'(p00_q) + prod);
					ST_P01: p01_q <= sat32(66'(p01_q) + prod);
					ST_P10: p10_q <= sat32(66'(p10_q) + prod);
					ST_P11: p11_q <= sat32(66'(p11_q) + prod);
					ST_UP00: p00_q <= sat32(66'(p00_q) - prod);
					ST_UP01: p01_q <= sat32(66'(p01_q) - prod);
					ST_UP10: p10_q <= sat32(66'(p10_q) - prod);
					ST_UP11: p11_q <= sat32(66'(p11_q) - prod);
					ST_UANG: angle_q <= sat32(66'(ang_q) + prod);
					ST_UBIAS: bias_q <= sat32(66'(bias_q) + prod);
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				meas_q <= in_ch.angle_meas;
				gyro_q <= in_ch.gyro_rate;
			end
			ST_RATE: rate_q <= sat32(66'(gyro_q) - 66'(bias_q));
			ST_ERR: err_q <= sat32(66'(meas_q) - 66'(ang_q));
			ST_PDOT: pdot_q <= sat32(66'(qa_q) - 66'(p01_q) - 66'(p10_q));
			ST_DIV0: begin
				fault_q <= (e_q == '0);
				if (e_q == '0) k0_q <= '0;
				else if (wait_q && !dbusy) k0_q <= sat32(66'(quo));
			end
			ST_DIV1: begin
				if (e_q == '0) k1_q <= '0;
				else if (wait_q && !dbusy) k1_q <= sat32(66'(quo));
			end
			ST_OUT: begin
				if (out_free) begin
					res_ang_q <= angle_q;
					res_bias_q <= bias_q;
					res_rate_q <= sat32(66'(gyro_q) - 66'(bias_q));
					res_fault_q <= fault_q;
				end
			end
			default: ;
		endcase
		if (wait_q) begin
			case (state_q)
				ST_ANG: ang_q <= sat32(66'(angle_q) + prod);
				ST_PC0: pc0_q <= sat32(prod);
				ST_PC1: pc1_q <= sat32(prod);
				ST_T1: t1_q <= sat32(prod);
				ST_E: e_q <= sat32(66'(r_q) + prod);
				default: ;
			endcase
		end
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.angle_est = res_ang_q;
	assign out_ch.rate_est = res_rate_q;
	assign out_ch.bias_est = res_bias_q;
	assign out_ch.div_fault = res_fault_q;

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !out_valid_q || state_q == ST_IDLE)
		else $error("ready outside idle");
	a_out_after_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_OUT)
		else $error("result without sequence end");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		dbusy |-> state_q == ST_DIV0 || state_q == ST_DIV1)
		else $error("divider busy outside division");

endmodule
